// ----- hdl/ab4_pkg.sv -----
`timescale 1ns / 1ps

package ab4_pkg;

	// Vector size and storage geometry
	localparam int ELEMENTS = 1024;
	localparam int ADDR_W   = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

	// Field widths
	localparam int IDX_W   = 10;
	localparam int DATA_W  = 32;
	localparam int SCALE_W = 24;
	localparam int HALF_W  = SCALE_W / 2;

	// Datapath widths: weighted sum, partial products, full product, increment
	localparam int S_W   = 40;
	localparam int PP_W  = S_W + HALF_W + 1;
	localparam int P_W   = S_W + SCALE_W;
	localparam int INC_W = P_W - SCALE_W;
	localparam int SUM_W = INC_W + 1;

	// APB register map
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_STEP_SCALE = 1'b0;

	// Output queue geometry
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_STEP = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0] h0;
		logic [DATA_W-1:0] h1;
		logic [DATA_W-1:0] h2;
	} hist_t;

	typedef struct packed {
		logic [DATA_W-1:0] state;
		hist_t             hist;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef struct packed {
		logic              sat;
		logic [DATA_W-1:0] state;
		logic [IDX_W-1:0]  idx;
	} out_item_t;

	// Map an element index onto a memory address
	function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
		logic [IDX_W+ADDR_W-1:0] ext;
		ext = {{ADDR_W{1'b0}}, idx};
		return ext[ADDR_W-1:0];
	endfunction

endpackage

// ----- hdl/ab4_ram.sv -----
`timescale 1ns / 1ps

module ab4_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port, read returns the old word on a collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/ab4_cfg.sv -----
`timescale 1ns / 1ps

module ab4_cfg
	import ab4_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [SCALE_W-1:0] step_scale
);

	logic [SCALE_W-1:0] step_scale_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// Take the register write in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_scale_q <= '0;
		end else if (wr_en && paddr[2] == REG_STEP_SCALE) begin
			step_scale_q <= pwdata[SCALE_W-1:0];
		end
	end

	// Return the register value, zero beyond the map
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_STEP_SCALE) begin
			prdata = {{(PDATA_W-SCALE_W){1'b0}}, step_scale_q};
		end
	end

	assign step_scale = step_scale_q;

endmodule

// ----- hdl/ab4_fifo.sv -----
`timescale 1ns / 1ps

module ab4_fifo
	import ab4_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  out_item_t             push_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item,
	output logic [FIFO_CNT_W-1:0] count
);

	out_item_t             mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_item  = mem_q[rd_ptr_q];
	assign count     = count_q;

	// Store the incoming result beat
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/adams_bashforth4_state_update.sv -----
`timescale 1ns / 1ps
// A result beat passes through stages 1 to 4 and the result queue before it is offered.
// Throughput: one item per cycle while s_tready is high, set by the single read and write
// port of the state memory; one element's step loop closes through a forwarding add and clamp.
// Input is held off only when the 8-entry result queue could not hold every item in flight.
// Reset clears pipeline valids, queue pointers and step_scale; memory is undefined until loaded.

module adams_bashforth4_state_update
	import ab4_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               s_tvalid,
	output logic               s_tready,
	// element_index, state_value, hist_oldest, hist_middle, hist_newest, deriv_new, zero pad
	input  logic [175:0]       s_tdata,
	// command
	input  logic [0:0]         s_tuser,
	output logic               m_tvalid,
	input  logic               m_tready,
	// result_index, new_state, zero pad
	output logic [47:0]        m_tdata,
	// saturated
	output logic [0:0]         m_tuser
);

	localparam logic signed [P_W-1:0] ROUND_HALF =
		{{(P_W-SCALE_W){1'b0}}, 1'b1, {(SCALE_W-1){1'b0}}};
	localparam logic signed [SUM_W-1:0] SAT_MAX =
		{{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_MIN =
		{{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
	localparam int WH_DEPTH = 4;

	// Configuration
	logic [SCALE_W-1:0] step_scale;

	ab4_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.step_scale (step_scale)
	);

	// Input beat unpacking
	logic              s_accept;
	logic [IDX_W-1:0]  in_idx;
	logic [DATA_W-1:0] in_state;
	hist_t             in_hist;
	logic [DATA_W-1:0] in_deriv;

	assign s_accept   = s_tvalid && s_tready;
	assign in_idx     = s_tdata[9:0];
	assign in_state   = s_tdata[41:10];
	assign in_hist.h0 = s_tdata[73:42];
	assign in_hist.h1 = s_tdata[105:74];
	assign in_hist.h2 = s_tdata[137:106];
	assign in_deriv   = s_tdata[169:138];

	// Pipeline registers
	logic                  v_s1, v_s2, v_s3, v_s4;
	cmd_t                  cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	logic [IDX_W-1:0]      idx_s1, idx_s2, idx_s3, idx_s4;
	logic                  inr_s1, inr_s2, inr_s3, inr_s4;
	logic [DATA_W-1:0]     state_s1;
	hist_t                 hist_s1;
	logic [DATA_W-1:0]     deriv_s1;
	logic [DATA_W-1:0]     base_s2, base_s3, base_s4;
	hist_t                 hist_s2, hist_s3, hist_s4;
	logic signed [S_W-1:0] sum_s2;
	logic signed [PP_W-1:0] pp_lo_s3, pp_hi_s3;
	logic signed [INC_W-1:0] inc_s4;

	// Recent writes, youngest first
	logic [WH_DEPTH-1:0] wh_v_q;
	logic [IDX_W-1:0]    wh_idx_q   [WH_DEPTH];
	logic [DATA_W-1:0]   wh_state_q [WH_DEPTH];
	hist_t               wh_hist_q;

	// State memory
	rec_t rd_rec;
	rec_t wr_rec;
	logic mem_we;

	ab4_ram #(
		.WIDTH (REC_W),
		.DEPTH (ELEMENTS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (to_addr(idx_s4)),
		.wdata (wr_rec),
		.re    (s_accept),
		.raddr (to_addr(in_idx)),
		.rdata (rd_rec)
	);

	// Result queue and credit
	logic                  push;
	out_item_t             push_item;
	out_item_t             out_item;
	logic [FIFO_CNT_W-1:0] fifo_count;
	logic [FIFO_CNT_W-1:0] occupancy;

	ab4_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_item  (out_item),
		.count     (fifo_count)
	);

	assign occupancy = fifo_count + FIFO_CNT_W'(v_s1) + FIFO_CNT_W'(v_s2)
		+ FIFO_CNT_W'(v_s3) + FIFO_CNT_W'(v_s4);
	assign s_tready  = (occupancy < FIFO_CNT_W'(FIFO_DEPTH));

	assign m_tdata = {6'b0, out_item.state, out_item.idx};
	assign m_tuser = out_item.sat;

	// Stage 1: forward history from items still in flight, build new history and sum
	hist_t                 fwd_hist;
	hist_t                 new_hist_s1;
	logic [DATA_W-1:0]     base_s1;
	logic signed [S_W-1:0] sum_s1;

	always_comb begin
		fwd_hist = rd_rec.hist;
		if (wh_v_q[0] && wh_idx_q[0] == idx_s1) begin
			fwd_hist = wh_hist_q;
		end
		if (v_s4 && inr_s4 && idx_s4 == idx_s1) begin
			fwd_hist = hist_s4;
		end
		if (v_s3 && inr_s3 && idx_s3 == idx_s1) begin
			fwd_hist = hist_s3;
		end
		if (v_s2 && inr_s2 && idx_s2 == idx_s1) begin
			fwd_hist = hist_s2;
		end
	end

	always_comb begin
		if (cmd_s1 == CMD_LOAD) begin
			new_hist_s1 = hist_s1;
			base_s1     = state_s1;
		end else begin
			new_hist_s1.h0 = fwd_hist.h1;
			new_hist_s1.h1 = fwd_hist.h2;
			new_hist_s1.h2 = deriv_s1;
			base_s1        = rd_rec.state;
		end
	end

	assign sum_s1 = S_W'(55) * S_W'($signed(deriv_s1))
		- S_W'(59) * S_W'($signed(fwd_hist.h2))
		+ S_W'(37) * S_W'($signed(fwd_hist.h1))
		- S_W'(9) * S_W'($signed(fwd_hist.h0));

	// Stage 2: split the scale multiply into two partial products
	logic signed [PP_W-1:0] pp_lo, pp_hi;

	assign pp_lo = PP_W'(sum_s2) * PP_W'($signed({1'b0, step_scale[HALF_W-1:0]}));
	assign pp_hi = PP_W'(sum_s2) * PP_W'($signed({1'b0, step_scale[SCALE_W-1:HALF_W]}));

	// Stage 3: combine, round half up, drop the fraction
	logic signed [P_W-1:0] prod;

	assign prod = (P_W'(pp_hi_s3) <<< HALF_W) + P_W'(pp_lo_s3) + ROUND_HALF;

	// Stage 4: forward state from recent writes, add and clamp
	logic [DATA_W-1:0]       cur_state;
	logic signed [SUM_W-1:0] upd;
	logic [DATA_W-1:0]       step_state;
	logic                    step_sat;
	logic [DATA_W-1:0]       new_state;

	always_comb begin
		cur_state = base_s4;
		for (int i = WH_DEPTH - 1; i >= 0; i--) begin
			if (wh_v_q[i] && wh_idx_q[i] == idx_s4) begin
				cur_state = wh_state_q[i];
			end
		end
	end

	assign upd = SUM_W'($signed(cur_state)) + SUM_W'(inc_s4);

	always_comb begin
		step_sat   = 1'b0;
		step_state = upd[DATA_W-1:0];
		if (upd > SAT_MAX) begin
			step_state = SAT_MAX[DATA_W-1:0];
			step_sat   = 1'b1;
		end else if (upd < SAT_MIN) begin
			step_state = SAT_MIN[DATA_W-1:0];
			step_sat   = 1'b1;
		end
	end

	assign new_state = (cmd_s4 == CMD_LOAD) ? base_s4 : step_state;
	assign mem_we    = v_s4 && inr_s4;
	assign wr_rec    = '{state: new_state, hist: hist_s4};

	always_comb begin
		push_item.idx   = idx_s4;
		push_item.state = inr_s4 ? new_state : '0;
		push_item.sat   = inr_s4 && (cmd_s4 == CMD_STEP) && step_sat;
	end

	assign push = v_s4;

	// Advance stage valids and write-tracking valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			wh_v_q <= '0;
		end else begin
			v_s1   <= s_accept;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			wh_v_q <= {wh_v_q[WH_DEPTH-2:0], mem_we};
		end
	end

	// Advance stage payloads
	always_ff @(posedge clk) begin
		cmd_s1   <= cmd_t'(s_tuser[0]);
		idx_s1   <= in_idx;
		inr_s1   <= ({{(32-IDX_W){1'b0}}, in_idx} < 32'(ELEMENTS));
		state_s1 <= in_state;
		hist_s1  <= in_hist;
		deriv_s1 <= in_deriv;

		cmd_s2  <= cmd_s1;
		idx_s2  <= idx_s1;
		inr_s2  <= inr_s1;
		base_s2 <= base_s1;
		hist_s2 <= new_hist_s1;
		sum_s2  <= sum_s1;

		cmd_s3   <= cmd_s2;
		idx_s3   <= idx_s2;
		inr_s3   <= inr_s2;
		base_s3  <= base_s2;
		hist_s3  <= hist_s2;
		pp_lo_s3 <= pp_lo;
		pp_hi_s3 <= pp_hi;

		cmd_s4  <= cmd_s3;
		idx_s4  <= idx_s3;
		inr_s4  <= inr_s3;
		base_s4 <= base_s3;
		hist_s4 <= hist_s3;
		inc_s4  <= $signed(prod[P_W-1:SCALE_W]);
	end

	// Shift the recent-write record
	always_ff @(posedge clk) begin
		wh_idx_q[0]   <= idx_s4;
		wh_state_q[0] <= new_state;
		wh_hist_q     <= hist_s4;
		for (int i = 1; i < WH_DEPTH; i++) begin
			wh_idx_q[i]   <= wh_idx_q[i-1];
			wh_state_q[i] <= wh_state_q[i-1];
		end
	end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import ab4_pkg::*;

	localparam logic [PADDR_W-1:0] SCALE_ADDR  = PADDR_W'(4 * int'(REG_STEP_SCALE));
	localparam int                 STUCK_LIMIT = 4000;
	localparam int                 DRAIN_CYCLES = 20;
	localparam int                 WORK_SET = 12;

	typedef struct {
		cmd_t              command;
		logic [IDX_W-1:0]  index;
		logic [DATA_W-1:0] state;
		logic [DATA_W-1:0] h0;
		logic [DATA_W-1:0] h1;
		logic [DATA_W-1:0] h2;
		logic [DATA_W-1:0] deriv;
	} beat_t;

	typedef struct {
		logic [IDX_W-1:0]  index;
		logic [DATA_W-1:0] state;
		logic              sat;
	} update_t;

	logic               clk;
	logic               arst_n  = 1'b0;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [PDATA_W-1:0] pwdata  = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	// element_index, state_value, hist_oldest, hist_middle, hist_newest, deriv_new, zero pad
	logic [175:0]       s_tdata  = '0;
	// command
	logic [0:0]         s_tuser  = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	// result_index, new_state, zero pad
	logic [47:0]        m_tdata;
	// saturated
	logic [0:0]         m_tuser;

	// Predicted element storage and scale
	logic [DATA_W-1:0]  elem_state [ELEMENTS];
	logic [DATA_W-1:0]  elem_h0 [ELEMENTS];
	logic [DATA_W-1:0]  elem_h1 [ELEMENTS];
	logic [DATA_W-1:0]  elem_h2 [ELEMENTS];
	logic [SCALE_W-1:0] step_scale_q = '0;

	beat_t   beats_to_send[$];
	update_t expected_states[$];

	int mismatches   = 0;
	int stuck_cycles = 0;
	int src_gap      = 0;
	int snk_stall    = 0;
	bit src_idle_en  = 1'b0;
	bit snk_idle_en  = 1'b0;
	bit in_accept    = 1'b0;
	int result_count = 0;

	adams_bashforth4_state_update u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Advance one element by a load or an Adams-Bashforth step
	function automatic update_t ab4_advance(input beat_t b);
		update_t r;
		longint  s;
		longint  inc;
		longint  v;
		r.index = b.index;
		r.state = '0;
		r.sat   = 1'b0;
		if (b.index < ELEMENTS) begin
			if (b.command == CMD_LOAD) begin
				elem_state[b.index] = b.state;
				elem_h0[b.index]    = b.h0;
				elem_h1[b.index]    = b.h1;
				elem_h2[b.index]    = b.h2;
			end else begin
				s = 55 * longint'($signed(b.deriv)) - 59 * longint'($signed(elem_h2[b.index]))
					+ 37 * longint'($signed(elem_h1[b.index]))
					- 9 * longint'($signed(elem_h0[b.index]));
				// round half up from Q16.40 back to Q16.16
				inc = (s * longint'(step_scale_q) + 64'sh80_0000) >>> 24;
				v = longint'($signed(elem_state[b.index])) + inc;
				if (v > 64'sd2147483647) begin
					v = 64'sd2147483647;
					r.sat = 1'b1;
				end else if (v < -64'sd2147483648) begin
					v = -64'sd2147483648;
					r.sat = 1'b1;
				end
				elem_state[b.index] = v[DATA_W-1:0];
				elem_h0[b.index]    = elem_h1[b.index];
				elem_h1[b.index]    = elem_h2[b.index];
				elem_h2[b.index]    = b.deriv;
			end
			r.state = elem_state[b.index];
		end
		return r;
	endfunction

	function automatic int pick_gap(input bit en);
		int r;
		if (!en)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// Mix full-range words, moderate values and the range ends
	function automatic logic [DATA_W-1:0] rand_q16();
		case ($urandom_range(0, 4))
			0, 1: return $urandom();
			2: return DATA_W'($urandom_range(0, 1 << 19)) - DATA_W'(1 << 18);
			3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
				: 32'h8000_0000 + $urandom_range(0, 3);
			default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
		endcase
	endfunction

	function automatic beat_t make_beat(input cmd_t c, input int idx, input logic [DATA_W-1:0] st,
		input logic [DATA_W-1:0] h0, input logic [DATA_W-1:0] h1,
		input logic [DATA_W-1:0] h2, input logic [DATA_W-1:0] d);
		beat_t b;
		b.command = c;
		b.index   = IDX_W'(idx);
		b.state   = st;
		b.h0      = h0;
		b.h1      = h1;
		b.h2      = h2;
		b.deriv   = d;
		return b;
	endfunction

	function automatic void queue_load(input int idx, input logic [DATA_W-1:0] st,
		input logic [DATA_W-1:0] h0, input logic [DATA_W-1:0] h1, input logic [DATA_W-1:0] h2);
		beats_to_send.push_back(make_beat(CMD_LOAD, idx, st, h0, h1, h2, rand_q16()));
	endfunction

	function automatic void queue_step(input int idx, input logic [DATA_W-1:0] d);
		beats_to_send.push_back(make_beat(CMD_STEP, idx, rand_q16(), rand_q16(), rand_q16(),
			rand_q16(), d));
	endfunction

	// Source: present the next beat once the current one is taken
	always @(negedge clk) begin
		beat_t b;
		if (in_accept || !s_tvalid) begin
			if (src_gap > 0) begin
				src_gap = src_gap - 1;
				s_tvalid <= 1'b0;
			end else if (beats_to_send.size() != 0) begin
				b = beats_to_send.pop_front();
				s_tdata  <= {6'b0, b.deriv, b.h2, b.h1, b.h0, b.state, b.index};
				s_tuser  <= b.command;
				s_tvalid <= 1'b1;
				src_gap = pick_gap(src_idle_en);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Sink: random stalls on the result side
	always @(negedge clk) begin
		if (snk_stall > 0) begin
			snk_stall = snk_stall - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (snk_idle_en && $urandom_range(0, 3) == 0)
				snk_stall = pick_gap(1'b1);
		end
	end

	task automatic check_field(input string name, input logic [DATA_W-1:0] exp_v,
		input logic [DATA_W-1:0] got_v);
		if (got_v !== exp_v) begin
			mismatches++;
			$display("%0t ns result %0d %s: expected 0x%08h, got 0x%08h", $time,
				result_count, name, exp_v, got_v);
		end
	endtask

	// Predict on each input beat, compare each result beat
	always @(posedge clk) begin
		beat_t   b;
		update_t e;
		in_accept <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			b.index   = s_tdata[9:0];
			b.state   = s_tdata[41:10];
			b.h0      = s_tdata[73:42];
			b.h1      = s_tdata[105:74];
			b.h2      = s_tdata[137:106];
			b.deriv   = s_tdata[169:138];
			b.command = cmd_t'(s_tuser[0]);
			expected_states.push_back(ab4_advance(b));
		end
		if (m_tvalid && m_tready) begin
			if (expected_states.size() == 0) begin
				mismatches++;
				$display("%0t ns result %0d: expected no beat, got index %0d state 0x%08h",
					$time, result_count, m_tdata[9:0], m_tdata[41:10]);
			end else begin
				e = expected_states.pop_front();
				check_field("result_index", DATA_W'(e.index), DATA_W'(m_tdata[9:0]));
				check_field("new_state", e.state, m_tdata[41:10]);
				check_field("saturated", DATA_W'(e.sat), DATA_W'(m_tuser[0]));
			end
			result_count++;
		end
	end

	// Watchdog: stop when no beat moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			stuck_cycles = 0;
		else
			stuck_cycles = stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("%0t ns no beat accepted for %0d cycles", $time, STUCK_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	task automatic wait_idle();
		while (beats_to_send.size() != 0 || s_tvalid || expected_states.size() != 0)
			@(posedge clk);
	endtask

	// Write step_scale, then read it back
	task automatic write_step_scale(input logic [SCALE_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= SCALE_ADDR;
		pwdata  <= PDATA_W'(val);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		step_scale_q = val;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== PDATA_W'(val)) begin
			mismatches++;
			$display("%0t ns step_scale readback: expected 0x%08h, got 0x%08h", $time,
				PDATA_W'(val), prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Load a small working set, then mostly steps on it with some reloads
	task automatic random_phase(input logic [SCALE_W-1:0] scale, input int n_items,
		input bit src_en, input bit snk_en, input bit pause_midway);
		int ws[WORK_SET];
		int r;
		wait_idle();
		write_step_scale(scale);
		src_idle_en = src_en;
		snk_idle_en = snk_en;
		for (int k = 0; k < WORK_SET; k++) begin
			ws[k] = $urandom_range(0, ELEMENTS - 1);
			if (k == 0 && $urandom_range(0, 1) == 1)
				ws[k] = 0;
			if (k == 1 && $urandom_range(0, 1) == 1)
				ws[k] = ELEMENTS - 1;
			queue_load(ws[k], rand_q16(), rand_q16(), rand_q16(), rand_q16());
		end
		for (int i = 0; i < n_items; i++) begin
			// hold the source until every result is back
			if (pause_midway && i == n_items / 2)
				wait_idle();
			r = $urandom_range(0, 99);
			if (r < 4)
				queue_load($urandom_range(0, ELEMENTS - 1), rand_q16(), rand_q16(), rand_q16(),
					rand_q16());
			else if (r < 14)
				queue_load(ws[$urandom_range(0, WORK_SET - 1)], rand_q16(), rand_q16(),
					rand_q16(), rand_q16());
			else
				queue_step(ws[$urandom_range(0, WORK_SET - 1)], rand_q16());
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Full scale: saturation both ways, zero step, all-ones data
		write_step_scale(24'hFF_FFFF);
		queue_load(0, 32'h7FFF_FFF0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		queue_step(0, 32'h7FFF_FFFF);
		queue_step(0, 32'h7FFF_FFFF);
		queue_load(ELEMENTS - 1, 32'h8000_0010, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		queue_step(ELEMENTS - 1, 32'h8000_0000);
		queue_load(512, 32'h0, 32'h0, 32'h0, 32'h0);
		queue_step(512, 32'h0);
		queue_step(512, 32'h1);
		queue_load(341, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_step(341, 32'hFFFF_FFFF);
		queue_load(682, 32'h1234_5678, rand_q16(), rand_q16(), rand_q16());
		queue_step(682, rand_q16());

		// Unit scale: weighted sum exactly at plus and minus one half LSB
		wait_idle();
		write_step_scale(24'h1);
		queue_load(3, 32'h0, 32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'h0);
		queue_step(3, 32'd152520);
		queue_load(4, 32'h0, 32'd5, 32'd1, 32'h0);
		queue_step(4, -32'sd152520);

		random_phase(24'h0, 200, 1'b0, 1'b0, 1'b0);
		random_phase(24'h1, 250, 1'b1, 1'b1, 1'b0);
		random_phase(SCALE_W'($urandom()), 250, 1'b1, 1'b1, 1'b1);
		random_phase(24'hFF_FFFF, 250, 1'b1, 1'b0, 1'b0);
		random_phase(SCALE_W'($urandom_range(1, 4095)), 250, 1'b0, 1'b1, 1'b0);
		random_phase(SCALE_W'($urandom()), 300, 1'b1, 1'b1, 1'b0);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
